/* rtl/hpt_pkg.sv */
`default_nettype none
package hpt_pkg;

    // Fixed port and register geometry.
    localparam int PORT_BITS     = 32;
    localparam int CFG_BITS      = 64;
    localparam int NUM_CFG_REGS  = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_DATA_BITS = 32;
    localparam int QUEUE_DEPTH   = 4;

    // Operation codes.
    localparam logic OP_VECTOR = 1'b0;
    localparam logic OP_POINT  = 1'b1;

    // Per-item classification carried from the front to the back.
    typedef struct packed {
        logic op;
        logic ovf;
        logic dz;
    } hpt_flags_t;

    // Reset value of a matrix register: the identity matrix.
    function automatic logic [CFG_BITS-1:0] cfg_reset_value(input int idx, input int frac);
        logic [CFG_BITS-1:0] one;
        one = CFG_BITS'(1) << frac;
        case (idx)
            0:       cfg_reset_value = one;
            2:       cfg_reset_value = one << 32;
            5:       cfg_reset_value = one;
            7:       cfg_reset_value = one << 32;
            default: cfg_reset_value = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

/* rtl/hpt_front.sv */
`default_nettype none
module hpt_front #(
    parameter int FRAC_BITS = hpt_pkg::DEF_FRAC_BITS,
    parameter int DATA_BITS = hpt_pkg::DEF_DATA_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              op,
    input  wire logic [hpt_pkg::PORT_BITS-1:0]     in_x,
    input  wire logic [hpt_pkg::PORT_BITS-1:0]     in_y,
    input  wire logic [hpt_pkg::PORT_BITS-1:0]     in_z,
    input  wire logic [hpt_pkg::PORT_BITS-1:0]     in_w,
    input  wire logic                              cfg_valid,
    input  wire logic [hpt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [hpt_pkg::CFG_BITS-1:0]      cfg_data,
    output logic                                   push_valid,
    input  wire logic                              push_full,
    output logic [4*DATA_BITS-1:0]                 push_res,
    output hpt_pkg::hpt_flags_t                    push_flags
);
    import hpt_pkg::*;

    localparam int PB = 2 * DATA_BITS;

    logic [CFG_BITS-1:0] mat_reg [NUM_CFG_REGS];
    logic signed [DATA_BITS-1:0] m [4][4];

    logic                        fe;
    logic                        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                        s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    logic signed [DATA_BITS-1:0] v_reg [4];
    logic signed [PB-1:0]        prod_reg [4][4];
    logic signed [PB:0]          pair_reg [4][2];
    logic signed [DATA_BITS-1:0] res_reg [4];
    logic [3:0]                  rov_reg;
    logic signed [DATA_BITS-1:0] res_next [4];
    logic [3:0]                  rov_next;

    // Matrix registers, written through the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG_REGS; i++)
            begin
                mat_reg[i] <= cfg_reset_value(i, FRAC_BITS);
            end
        end
        else if (cfg_valid)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    // Matrix elements: even column in the low half, odd column in the high half.
    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign m[r][c] = mat_reg[2 * r + c / 2][(c % 2) * 32 +: DATA_BITS];
        end
    end

    // The pipeline moves unless a finished item cannot enter the queue.
    assign fe         = !(s4_valid_reg && push_full);
    assign in_stall   = !fe;
    assign push_valid = s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (fe)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: capture the vector; a point has w fixed at 1.0.
    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            s1_op_reg <= op;
            v_reg[0]  <= in_x[DATA_BITS-1:0];
            v_reg[1]  <= in_y[DATA_BITS-1:0];
            v_reg[2]  <= in_z[DATA_BITS-1:0];
            v_reg[3]  <= (op == OP_POINT) ? (DATA_BITS'(1) << FRAC_BITS) : in_w[DATA_BITS-1:0];
        end
    end

    // Stage 2: sixteen products. Stage 3: pair sums.
    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            s2_op_reg <= s1_op_reg;
            s3_op_reg <= s2_op_reg;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= m[r][c] * v_reg[c];
                end
                pair_reg[r][0] <= (PB+1)'(prod_reg[r][0]) + (PB+1)'(prod_reg[r][1]);
                pair_reg[r][1] <= (PB+1)'(prod_reg[r][2]) + (PB+1)'(prod_reg[r][3]);
            end
        end
    end

    // Final sum, floor shift and saturation of each row.
    always_comb
    begin
        logic signed [PB+1:0] sum;
        logic signed [PB+1:0] sh;
        logic signed [PB+1:0] hi;
        logic signed [PB+1:0] lo;
        hi = (PB+2)'((PB+2)'(1) << (DATA_BITS - 1)) - (PB+2)'(1);
        lo = -hi - (PB+2)'(1);
        for (int r = 0; r < 4; r++)
        begin
            sum = (PB+2)'(pair_reg[r][0]) + (PB+2)'(pair_reg[r][1]);
            sh  = sum >>> FRAC_BITS;
            if (sh > hi)
            begin
                res_next[r] = hi[DATA_BITS-1:0];
                rov_next[r] = 1'b1;
            end
            else if (sh < lo)
            begin
                res_next[r] = lo[DATA_BITS-1:0];
                rov_next[r] = 1'b1;
            end
            else
            begin
                res_next[r] = sh[DATA_BITS-1:0];
                rov_next[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            s4_op_reg <= s3_op_reg;
            rov_reg   <= rov_next;
            for (int r = 0; r < 4; r++)
            begin
                res_reg[r] <= res_next[r];
            end
        end
    end

    // Classify the item for the back end.
    assign push_res = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
    assign push_flags.op  = s4_op_reg;
    assign push_flags.ovf = (s4_op_reg == OP_POINT) ? rov_reg[3] : (|rov_reg);
    assign push_flags.dz  = (s4_op_reg == OP_POINT) && (res_reg[3] == '0);

endmodule
`default_nettype wire

/* rtl/hpt_queue.sv */
`default_nettype none
module hpt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hpt_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop && !empty)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push && !full) - CW'(pop && !empty);
        end
    end

endmodule
`default_nettype wire

/* rtl/hpt_back.sv */
`default_nettype none
module hpt_back #(
    parameter int FRAC_BITS = hpt_pkg::DEF_FRAC_BITS,
    parameter int DATA_BITS = hpt_pkg::DEF_DATA_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    output logic                               q_pop,
    input  wire logic [4*DATA_BITS-1:0]        q_res,
    input  wire hpt_pkg::hpt_flags_t           q_flags,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [hpt_pkg::PORT_BITS-1:0]      out_x,
    output logic [hpt_pkg::PORT_BITS-1:0]      out_y,
    output logic [hpt_pkg::PORT_BITS-1:0]      out_z,
    output logic [hpt_pkg::PORT_BITS-1:0]      out_w,
    output logic                               overflow,
    output logic                               div_zero
);
    import hpt_pkg::*;

    // One quotient bit per stage.
    localparam int NB = DATA_BITS + FRAC_BITS;
    localparam int NS = NB + 1;

    logic                        be;
    logic                        valid_reg [NS];
    hpt_flags_t                  flags_reg [NS];
    logic [4*DATA_BITS-1:0]      res_reg [NS];
    logic [DATA_BITS-1:0]        dmag_reg [NS];
    logic [2:0]                  neg_reg [NS];
    logic [DATA_BITS:0]          rem_reg [NS][3];
    logic [NB-1:0]               q_reg [NS][3];

    logic                        out_valid_reg;
    logic [DATA_BITS-1:0]        ox_reg, oy_reg, oz_reg, ow_reg;
    logic                        ovf_reg, dz_reg;
    logic [DATA_BITS-1:0]        quo [3];
    logic [2:0]                  qsat;

    // The whole divider advances unless a result waits at the output.
    assign be    = !(out_valid_reg && out_stall);
    assign q_pop = be && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (be)
        begin
            valid_reg[0] <= !q_empty;
            for (int i = 0; i < NS - 1; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    // Stage 0: magnitudes of the dividends (value shifted by the fraction) and of w.
    always_ff @(posedge clk)
    begin
        logic [DATA_BITS-1:0] w;
        logic [DATA_BITS-1:0] v;
        logic [DATA_BITS-1:0] vmag;
        if (be)
        begin
            w = q_res[3*DATA_BITS +: DATA_BITS];
            flags_reg[0] <= q_flags;
            res_reg[0]   <= q_res;
            dmag_reg[0]  <= w[DATA_BITS-1] ? (~w + DATA_BITS'(1)) : w;
            for (int l = 0; l < 3; l++)
            begin
                v    = q_res[l*DATA_BITS +: DATA_BITS];
                vmag = v[DATA_BITS-1] ? (~v + DATA_BITS'(1)) : v;
                neg_reg[0][l]  <= v[DATA_BITS-1] ^ w[DATA_BITS-1];
                rem_reg[0][l]  <= '0;
                q_reg[0][l]    <= {vmag, FRAC_BITS'(0)};
            end
        end
    end

    // Restoring division, one bit per stage for each lane.
    for (genvar s = 0; s < NB; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            logic [DATA_BITS:0] a;
            logic [NB-1:0]      qs;
            if (be)
            begin
                flags_reg[s+1] <= flags_reg[s];
                res_reg[s+1]   <= res_reg[s];
                dmag_reg[s+1]  <= dmag_reg[s];
                neg_reg[s+1]   <= neg_reg[s];
                for (int l = 0; l < 3; l++)
                begin
                    a  = {rem_reg[s][l][DATA_BITS-1:0], q_reg[s][l][NB-1]};
                    qs = q_reg[s][l] << 1;
                    if (a >= {1'b0, dmag_reg[s]})
                    begin
                        rem_reg[s+1][l] <= a - {1'b0, dmag_reg[s]};
                        q_reg[s+1][l]   <= qs | NB'(1);
                    end
                    else
                    begin
                        rem_reg[s+1][l] <= a;
                        q_reg[s+1][l]   <= qs;
                    end
                end
            end
        end
    end

    // Signed floor quotient and saturation.
    always_comb
    begin
        logic signed [NB+1:0] qq;
        logic signed [NB+1:0] hi;
        logic signed [NB+1:0] lo;
        hi = (NB+2)'((NB+2)'(1) << (DATA_BITS - 1)) - (NB+2)'(1);
        lo = -hi - (NB+2)'(1);
        for (int l = 0; l < 3; l++)
        begin
            qq = {2'b00, q_reg[NB][l]};
            if (neg_reg[NB][l])
            begin
                qq = -qq - (NB+2)'(rem_reg[NB][l] != '0);
            end
            if (qq > hi)
            begin
                quo[l]  = hi[DATA_BITS-1:0];
                qsat[l] = 1'b1;
            end
            else if (qq < lo)
            begin
                quo[l]  = lo[DATA_BITS-1:0];
                qsat[l] = 1'b1;
            end
            else
            begin
                quo[l]  = qq[DATA_BITS-1:0];
                qsat[l] = 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (be)
        begin
            out_valid_reg <= valid_reg[NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            ow_reg <= res_reg[NB][3*DATA_BITS +: DATA_BITS];
            if (flags_reg[NB].op == OP_VECTOR)
            begin
                ox_reg  <= res_reg[NB][0 +: DATA_BITS];
                oy_reg  <= res_reg[NB][DATA_BITS +: DATA_BITS];
                oz_reg  <= res_reg[NB][2*DATA_BITS +: DATA_BITS];
                ovf_reg <= flags_reg[NB].ovf;
                dz_reg  <= 1'b0;
            end
            else if (flags_reg[NB].dz)
            begin
                ox_reg  <= '0;
                oy_reg  <= '0;
                oz_reg  <= '0;
                ovf_reg <= 1'b0;
                dz_reg  <= 1'b1;
            end
            else
            begin
                ox_reg  <= quo[0];
                oy_reg  <= quo[1];
                oz_reg  <= quo[2];
                ovf_reg <= flags_reg[NB].ovf | (|qsat);
                dz_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = PORT_BITS'($signed(ox_reg));
    assign out_y     = PORT_BITS'($signed(oy_reg));
    assign out_z     = PORT_BITS'($signed(oz_reg));
    assign out_w     = PORT_BITS'($signed(ow_reg));
    assign overflow  = ovf_reg;
    assign div_zero  = dz_reg;

endmodule
`default_nettype wire

/* rtl/homogeneous_point_transform_unit.sv */
`default_nettype none
// Transforms one 4-vector per cycle, unless in_stall is high, by a configured 4x4
// fixed-point matrix (identity after reset). With op 1 the input is a point with w
// taken as 1.0 and x, y, z are divided by the computed w. A new item is taken every
// cycle while in_stall is low; the path runs through 4 front stages, the queue,
// DATA_BITS + FRAC_BITS + 1 divider stages and the output register. The default
// format is Q16.16. The user must write the matrix registers only while the block
// is idle; the block itself does not enforce this. cfg_ready is always high.
module homogeneous_point_transform_unit #(
    parameter int FRAC_BITS = hpt_pkg::DEF_FRAC_BITS,
    parameter int DATA_BITS = hpt_pkg::DEF_DATA_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              op,
    input  wire logic [hpt_pkg::PORT_BITS-1:0]     in_x,
    input  wire logic [hpt_pkg::PORT_BITS-1:0]     in_y,
    input  wire logic [hpt_pkg::PORT_BITS-1:0]     in_z,
    input  wire logic [hpt_pkg::PORT_BITS-1:0]     in_w,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [hpt_pkg::PORT_BITS-1:0]          out_x,
    output logic [hpt_pkg::PORT_BITS-1:0]          out_y,
    output logic [hpt_pkg::PORT_BITS-1:0]          out_z,
    output logic [hpt_pkg::PORT_BITS-1:0]          out_w,
    output logic                                   overflow,
    output logic                                   div_zero,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hpt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [hpt_pkg::CFG_BITS-1:0]      cfg_data
);
    import hpt_pkg::*;

    localparam int QW = 4 * DATA_BITS + $bits(hpt_flags_t);

    logic                   push_valid, q_full, q_empty, q_pop;
    logic [4*DATA_BITS-1:0] push_res, q_res;
    hpt_flags_t             push_flags, q_flags;
    logic [QW-1:0]          q_rdata;

    assign cfg_ready = 1'b1;

    // Front: matrix products and row sums.
    hpt_front #(.FRAC_BITS(FRAC_BITS), .DATA_BITS(DATA_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_z       (in_z),
        .in_w       (in_w),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_full  (q_full),
        .push_res   (push_res),
        .push_flags (push_flags)
    );

    // Queue between the front and the divider.
    hpt_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_valid),
        .wdata ({push_flags, push_res}),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    assign q_res   = q_rdata[4*DATA_BITS-1:0];
    assign q_flags = q_rdata[QW-1:4*DATA_BITS];

    // Back: perspective divide and output register.
    hpt_back #(.FRAC_BITS(FRAC_BITS), .DATA_BITS(DATA_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_res     (q_res),
        .q_flags   (q_flags),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .overflow  (overflow),
        .div_zero  (div_zero)
    );

endmodule
`default_nettype wire

/* dv/homogeneous_point_transform_unit_tb.sv */
`default_nettype none
module homogeneous_point_transform_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hpt_pkg::*;

    typedef struct {
        logic        op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
    } point_item_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        ovf;
        logic        dz;
    } transform_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = 1'b0;
    logic [31:0] in_x = '0;
    logic [31:0] in_y = '0;
    logic [31:0] in_z = '0;
    logic [31:0] in_w = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] out_x, out_y, out_z, out_w;
    logic overflow, div_zero;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    // Matrix copy kept in step with the register writes.
    longint matrix [4][4];
    point_item_t pending_items [$];
    transform_res_t expected_results [$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 1'b0;

    homogeneous_point_transform_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
        .overflow(overflow), .div_zero(div_zero),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Saturate to 32 signed bits and flag it.
    function automatic longint clamp32(input logic signed [66:0] v, inout bit ovf);
        if (v > 67'sd2147483647)
        begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -67'sd2147483648)
        begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return longint'(v);
    endfunction

    // Exact row dot product, floored by the fraction shift, then saturated.
    function automatic longint row_dot(input int r, input longint v [4], inout bit ovf);
        logic signed [66:0] acc;
        acc = '0;
        for (int c = 0; c < 4; c++)
            acc = acc + 67'(matrix[r][c] * v[c]);
        acc = acc >>> DEF_FRAC_BITS;
        return clamp32(acc, ovf);
    endfunction

    // Floored fixed-point quotient, saturated.
    function automatic longint fixed_div(input longint v, input longint w, inout bit ovf);
        longint n, q;
        n = v * 65536;
        q = n / w;
        if ((n % w) != 0 && ((n < 0) != (w < 0)))
            q--;
        return clamp32(67'(q), ovf);
    endfunction

    function automatic transform_res_t transform_point(input point_item_t it);
        longint v [4];
        longint res [4];
        bit ovf, wovf;
        transform_res_t t;
        ovf = 1'b0;
        wovf = 1'b0;
        v[0] = longint'(signed'(it.x));
        v[1] = longint'(signed'(it.y));
        v[2] = longint'(signed'(it.z));
        v[3] = longint'(signed'(it.w));
        if (it.op == OP_POINT)
            v[3] = 65536;
        for (int r = 0; r < 3; r++)
            res[r] = row_dot(r, v, ovf);
        res[3] = row_dot(3, v, wovf);
        t.dz = 1'b0;
        if (it.op == OP_VECTOR)
        begin
            ovf = ovf | wovf;
        end
        else if (res[3] == 0)
        begin
            t.dz = 1'b1;
            ovf = 1'b0;
            res[0] = 0;
            res[1] = 0;
            res[2] = 0;
        end
        else
        begin
            // With a divide only w and the quotients count toward overflow.
            ovf = wovf;
            for (int r = 0; r < 3; r++)
                res[r] = fixed_div(res[r], res[3], ovf);
        end
        t.x = res[0][31:0];
        t.y = res[1][31:0];
        t.z = res[2][31:0];
        t.w = res[3][31:0];
        t.ovf = ovf;
        return t;
    endfunction

    // Driver: offers the next pending item unless the current one is stalled.
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                point_item_t it;
                it = pending_items.pop_front();
                op <= it.op;
                in_x <= it.x;
                in_y <= it.y;
                in_z <= it.z;
                in_w <= it.w;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with an optional long hold-off.
    always @(posedge clk)
    begin
        out_stall <= recv_hold || ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Monitor: predicts accepted items and checks accepted results.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_results.push_back(transform_point('{op, in_x, in_y, in_z, in_w}));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item pending, actual %h %h %h %h",
                         $time, out_x, out_y, out_z, out_w);
            end
            else
            begin
                transform_res_t e;
                e = expected_results.pop_front();
                check_field("out_x", e.x, out_x);
                check_field("out_y", e.y, out_y);
                check_field("out_z", e.z, out_z);
                check_field("out_w", e.w, out_w);
                check_field("overflow", 32'(e.ovf), 32'(overflow));
                check_field("div_zero", 32'(e.dz), 32'(div_zero));
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
            2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
            3: return ($urandom_range(0, 1)) ? 32'h00010000 : 32'hffff0000;
            default: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
        endcase
    endfunction

    function automatic logic [31:0] rand_entry(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
            default: return 32'h0;
        endcase
    endfunction

    task automatic write_reg(input int idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_BITS-1:0];
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        matrix[idx / 2][(idx % 2) * 2] = longint'(signed'(value[31:0]));
        matrix[idx / 2][(idx % 2) * 2 + 1] = longint'(signed'(value[63:32]));
    endtask

    // Writes all eight registers; the w row gets its own kind.
    task automatic load_matrix(input int kind, input int w_kind);
        for (int i = 0; i < NUM_CFG_REGS; i++)
            write_reg(i, {rand_entry(i >= 6 ? w_kind : kind),
                          rand_entry(i >= 6 ? w_kind : kind)});
    endtask

    task automatic push_item(input logic o, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w);
        pending_items.push_back('{o, x, y, z, w});
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CFG_REGS; i++)
        begin
            logic [63:0] rv;
            rv = cfg_reset_value(i, DEF_FRAC_BITS);
            matrix[i / 2][(i % 2) * 2] = longint'(signed'(rv[31:0]));
            matrix[i / 2][(i % 2) * 2 + 1] = longint'(signed'(rv[63:32]));
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items on the identity matrix.
        push_item(OP_VECTOR, 32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000);
        push_item(OP_VECTOR, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000);
        push_item(OP_VECTOR, 32'hffffffff, 32'h00000001, 32'h7fffffff, 32'h7fffffff);
        push_item(OP_POINT, 32'h00020000, 32'hfffe0000, 32'h00008000, 32'h12345678);
        push_item(OP_POINT, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0);
        drain();

        // Saturating matrix: large products and quotients.
        for (int i = 0; i < NUM_CFG_REGS; i++)
            write_reg(i, 64'h7fffffff_7fffffff);
        push_item(OP_VECTOR, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        push_item(OP_VECTOR, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        push_item(OP_POINT, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'h0);
        push_item(OP_POINT, 32'h00000001, 32'h0, 32'h0, 32'h0);
        drain();
        for (int i = 0; i < NUM_CFG_REGS; i++)
            write_reg(i, 64'h80000000_80000000);
        push_item(OP_VECTOR, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        push_item(OP_POINT, 32'h00010000, 32'hffff0000, 32'h7fffffff, 32'h0);
        push_item(OP_POINT, 32'hffffffff, 32'h00000001, 32'h0, 32'h5);
        drain();

        // Zero w row: every point divides by zero.
        load_matrix(1, 3);
        push_item(OP_POINT, 32'h00030000, 32'h80000000, 32'h7fffffff, 32'h1);
        push_item(OP_POINT, 32'h0, 32'h0, 32'h0, 32'h0);
        push_item(OP_VECTOR, 32'h00030000, 32'hfffd0000, 32'h1, 32'h7fffffff);
        drain();

        // Random phases; idling changes every two phases.
        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 65 : 0;
            recv_idle_pct = (phase < 2) ? 65 : (phase < 4) ? 26 : 0;
            load_matrix($urandom_range(0, 3) == 0 ? 0 : 1, $urandom_range(0, 4) == 0 ? 0 : 1);
            for (int n = 0; n < 125; n++)
                push_item($urandom_range(0, 1), rand_value(), rand_value(),
                          rand_value(), rand_value());
            if (phase == 1)
            begin
                // Hold the output long enough for the block to back up.
                recv_hold = 1'b1;
                repeat (300) @(posedge clk);
                recv_hold = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(12 * 1000000);
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
